// File: sv/priority_task_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/pts_pkg.sv
package pts_pkg;

    // Default table size and fixed field widths.
    localparam int NUM_TASKS_DEF = 8;
    localparam int ACTION_W      = 3;
    localparam int IDX_W         = 3;
    localparam int PRIO_W        = 8;
    localparam int TICK_W        = 32;

    // Command codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE = 3'd0,
        ACT_LAUNCH = 3'd1,
        ACT_TICK   = 3'd2,
        ACT_BLOCK  = 3'd3,
        ACT_RESUME = 3'd4,
        ACT_DELAY  = 3'd5
    } action_t;

    // Per-task state codes.
    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DELAYED = 2'd3
    } task_st_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_MARK,
        SEQ_DONE
    } seq_state_t;

endpackage

// File: sv/priority_task_scheduler.sv
// Fixed-priority task scheduler.
// Input channel (in_valid/in_stall) takes one command beat: action, task_index,
// priority_req and delay_ticks. Output channel (out_valid/out_stall) returns one
// beat per command with the running task, the create result and the tick count.
// A command that edits the table only (create, zero delay, unused codes) goes from
// accept straight to the final state. Launch, tick, block, resume and delay scan
// the created task entries one per cycle through a shared compare unit, then pass
// through the mark state to the final state.
// A new command is taken only while the sequencer is idle, so the block finishes
// each command before it takes the next.
// The output beat sits in a register; while out_stall is high it holds, and the
// sequencer waits in its final state until the register is free. The input side
// may already hand over the next command while a finished beat waits.
// Reset clears the task count, the running task, the tick count and both valid
// flags; task entries are written on create and need no clearing.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [IDX_W-1:0]  task_index,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TICK_W-1:0] delay_ticks,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  current_task,
    output logic              current_valid,
    output logic [IDX_W-1:0]  created_index,
    output logic              create_ok,
    output logic [TICK_W-1:0] tick_now
);

`include "priority_task_scheduler_defines.svh"

    localparam int TASK_IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W   = $clog2(NUM_TASKS + 1);
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // Task table.
    task_st_t            st_mem   [NUM_TASKS];
    logic [PRIO_W-1:0]   prio_mem [NUM_TASKS];
    logic [TICK_W-1:0]   wake_mem [NUM_TASKS];

    // Control registers.
    seq_state_t          seq_reg, seq_next;
    logic [TASK_IW-1:0]  ptr_reg, ptr_next;
    logic [PRIO_W-1:0]   best_reg, best_next;
    logic                tick_mode_reg, tick_mode_next;
    logic [TASK_IW-1:0]  run_idx_reg, run_idx_next;
    logic                run_valid_reg, run_valid_next;
    logic [CNT_W-1:0]    created_reg, created_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [IDX_W-1:0]   new_idx_reg, new_idx_next;
    logic                new_ok_reg, new_ok_next;
    logic                out_valid_reg, out_valid_next;

    // Output payload registers.
    logic [IDX_W-1:0]    cur_task_reg;
    logic                cur_valid_reg;
    logic [IDX_W-1:0]    cr_idx_reg;
    logic                cr_ok_reg;
    logic [TICK_W-1:0]   tick_out_reg;

    logic                accept;
    logic                out_load;
    logic                room;
    logic                target_ok;
    logic                delay_nz;
    logic [CMP_W-1:0]    idx_wide;
    logic [CMP_W-1:0]    slot_wide;
    logic [CMP_W-1:0]    run_wide;
    logic [TASK_IW-1:0]  idx_addr;
    logic [TASK_IW-1:0]  slot_addr;
    logic                scan_last;
    task_st_t            st_cur;
    task_st_t            st_new;
    logic                pick;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (seq_reg != SEQ_IDLE);
    assign room      = (created_reg < CNT_W'(NUM_TASKS));
    assign idx_wide  = CMP_W'(task_index);
    assign slot_wide = CMP_W'(created_reg);
    assign run_wide  = CMP_W'(run_idx_reg);
    assign idx_addr  = idx_wide[TASK_IW-1:0];
    assign slot_addr = slot_wide[TASK_IW-1:0];
    assign target_ok = (idx_wide < CMP_W'(created_reg));
    assign delay_nz  = (delay_ticks != '0);
    assign scan_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == created_reg);

    // Shared per-entry unit: tick update of one entry and the priority compare.
    always_comb
    begin
        st_cur = st_mem[ptr_reg];
        st_new = st_cur;
        if (tick_mode_reg)
        begin
            if (st_cur == TS_RUNNING)
            begin
                st_new = TS_READY;
            end
            else if (st_cur == TS_DELAYED && wake_mem[ptr_reg] == tick_reg)
            begin
                st_new = TS_READY;
            end
        end
        pick = (st_new == TS_READY) && (prio_mem[ptr_reg] > best_reg);
    end

    // Sequencer: next state and control updates.
    always_comb
    begin
        seq_next       = seq_reg;
        ptr_next       = ptr_reg;
        best_next      = best_reg;
        tick_mode_next = tick_mode_reg;
        run_idx_next   = run_idx_reg;
        run_valid_next = run_valid_reg;
        created_next   = created_reg;
        tick_next      = tick_reg;
        new_idx_next   = new_idx_reg;
        new_ok_next    = new_ok_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    ptr_next       = '0;
                    best_next      = '0;
                    new_idx_next   = '0;
                    new_ok_next    = 1'b0;
                    tick_mode_next = 1'b0;
                    seq_next       = SEQ_DONE;
                    case (action)
                        ACT_CREATE:
                        begin
                            if (room)
                            begin
                                new_idx_next = slot_wide[IDX_W-1:0];
                                new_ok_next  = 1'b1;
                                created_next = created_reg + CNT_W'(1);
                            end
                        end
                        ACT_LAUNCH:
                        begin
                            seq_next = (created_reg == '0) ? SEQ_MARK : SEQ_SCAN;
                        end
                        ACT_TICK, ACT_BLOCK, ACT_RESUME:
                        begin
                            tick_mode_next = 1'b1;
                            seq_next = (created_reg == '0) ? SEQ_MARK : SEQ_SCAN;
                        end
                        ACT_DELAY:
                        begin
                            if (delay_nz)
                            begin
                                tick_mode_next = 1'b1;
                                seq_next = (created_reg == '0) ? SEQ_MARK : SEQ_SCAN;
                            end
                        end
                        default:
                        begin
                            seq_next = SEQ_DONE;
                        end
                    endcase
                end
            end
            SEQ_SCAN:
            begin
                if (pick)
                begin
                    best_next      = prio_mem[ptr_reg];
                    run_idx_next   = ptr_reg;
                    run_valid_next = 1'b1;
                end
                ptr_next = ptr_reg + TASK_IW'(1);
                if (scan_last)
                begin
                    seq_next = SEQ_MARK;
                end
            end
            SEQ_MARK:
            begin
                if (tick_mode_reg)
                begin
                    tick_next = tick_reg + TICK_W'(1);
                end
                seq_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    seq_next       = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_IDLE;
            ptr_reg       <= '0;
            best_reg      <= '0;
            tick_mode_reg <= 1'b0;
            run_idx_reg   <= '0;
            run_valid_reg <= 1'b0;
            created_reg   <= '0;
            tick_reg      <= '0;
            new_idx_reg   <= '0;
            new_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            ptr_reg       <= ptr_next;
            best_reg      <= best_next;
            tick_mode_reg <= tick_mode_next;
            run_idx_reg   <= run_idx_next;
            run_valid_reg <= run_valid_next;
            created_reg   <= created_next;
            tick_reg      <= tick_next;
            new_idx_reg   <= new_idx_next;
            new_ok_reg    <= new_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Task table writes: command edits on accept, scan write-back, final mark.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (action)
                ACT_CREATE:
                begin
                    if (room)
                    begin
                        prio_mem[slot_addr] <= priority_req;
                        st_mem[slot_addr]   <= TS_READY;
                    end
                end
                ACT_BLOCK:
                begin
                    if (target_ok)
                    begin
                        st_mem[idx_addr] <= TS_BLOCKED;
                    end
                end
                ACT_RESUME:
                begin
                    if (target_ok)
                    begin
                        st_mem[idx_addr] <= TS_READY;
                    end
                end
                ACT_DELAY:
                begin
                    if (target_ok && delay_nz)
                    begin
                        wake_mem[idx_addr] <= delay_ticks + tick_reg;
                        st_mem[idx_addr]   <= TS_DELAYED;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (seq_reg == SEQ_SCAN)
        begin
            st_mem[ptr_reg] <= st_new;
        end
        else if (seq_reg == SEQ_MARK && run_valid_reg)
        begin
            st_mem[run_idx_reg] <= TS_RUNNING;
        end
    end

    // Output beat register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cur_task_reg  <= run_valid_reg ? run_wide[IDX_W-1:0] : '0;
            cur_valid_reg <= run_valid_reg;
            cr_idx_reg    <= new_idx_reg;
            cr_ok_reg     <= new_ok_reg;
            tick_out_reg  <= tick_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign current_task  = cur_task_reg;
    assign current_valid = cur_valid_reg;
    assign created_index = cr_idx_reg;
    assign create_ok     = cr_ok_reg;
    assign tick_now      = tick_out_reg;

    // Checks on the sequencer and the scheduler state.
    `PTS_ASSERT_NEXT(a_accept_busy, accept, seq_reg != SEQ_IDLE, "accepted command did not start")
    `PTS_ASSERT_NOW(a_scan_bound, seq_reg == SEQ_SCAN, CNT_W'(ptr_reg) < created_reg, "scan past table")
    `PTS_ASSERT_NEXT(a_run_sticky, run_valid_reg, run_valid_reg, "running flag dropped")
    `PTS_ASSERT_NEXT(a_tick_hold, seq_reg != SEQ_MARK, $stable(tick_reg), "tick moved outside mark")

endmodule

// File: verif/priority_task_scheduler_tb.sv
module priority_task_scheduler_tb;
    import pts_pkg::*;

    localparam int NTASK = NUM_TASKS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_CMDS = 1600;

    // Command codes that the package leaves unnamed; the block must ignore them.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    // One status beat as the block reports it.
    typedef struct packed {
        logic [IDX_W-1:0]  cur_task;
        logic              cur_valid;
        logic [IDX_W-1:0]  slot;
        logic              slot_ok;
        logic [TICK_W-1:0] ticks;
    } sched_status_t;

    // One row of the directed command table.
    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [IDX_W-1:0]    ix;
        logic [PRIO_W-1:0]   pr;
        logic [TICK_W-1:0]   dl;
        logic                typed;
        sched_status_t       res;
    } cmd_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]  task_index;
    logic [PRIO_W-1:0] priority_req;
    logic [TICK_W-1:0] delay_ticks;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  current_task;
    logic              current_valid;
    logic [IDX_W-1:0]  created_index;
    logic              create_ok;
    logic [TICK_W-1:0] tick_now;

    // Shadow copy of the task table and the scheduler registers.
    task_st_t          tsk_state [NTASK];
    logic [PRIO_W-1:0] tsk_prio [NTASK];
    logic [TICK_W-1:0] tsk_wake [NTASK];
    int unsigned       n_created = 0;
    logic [IDX_W-1:0]  run_idx = '0;
    logic              run_vld = 1'b0;
    logic [TICK_W-1:0] tick_cnt = '0;

    sched_status_t status_q [$];
    cmd_row_t      rows [$];
    int            errors = 0;
    int            n_sent = 0;
    int            n_checked = 0;
    int            snd_idle = 16;
    int            rcv_idle = 59;
    int            idle_cycles = 0;

    priority_task_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .task_index    (task_index),
        .priority_req  (priority_req),
        .delay_ticks   (delay_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_task  (current_task),
        .current_valid (current_valid),
        .created_index (created_index),
        .create_ok     (create_ok),
        .tick_now      (tick_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick the first ready task with the strictly highest nonzero priority.
    function void pick_highest();
        logic [PRIO_W-1:0] best;
        best = '0;
        for (int i = 0; i < n_created; i++)
        begin
            if (tsk_state[i] == TS_READY && tsk_prio[i] > best)
            begin
                best = tsk_prio[i];
                run_idx = i[IDX_W-1:0];
                run_vld = 1'b1;
            end
        end
        if (run_vld)
            tsk_state[run_idx] = TS_RUNNING;
    endfunction

    // Demote running tasks, wake due delayed tasks, reselect, advance time.
    function void advance_tick();
        for (int i = 0; i < n_created; i++)
        begin
            if (tsk_state[i] == TS_RUNNING)
                tsk_state[i] = TS_READY;
        end
        for (int i = 0; i < n_created; i++)
        begin
            if (tsk_state[i] == TS_DELAYED && tsk_wake[i] == tick_cnt)
            begin
                tsk_state[i] = TS_READY;
                tsk_wake[i] = '0;
            end
        end
        pick_highest();
        tick_cnt = tick_cnt + 1'b1;
    endfunction

    // Apply one command to the shadow scheduler and return the status it reports.
    function sched_status_t schedule_cmd(input logic [ACTION_W-1:0] a,
                                         input logic [IDX_W-1:0] ix,
                                         input logic [PRIO_W-1:0] pr,
                                         input logic [TICK_W-1:0] dl);
        sched_status_t st;
        logic          target_ok;
        st = '0;
        target_ok = (ix < n_created);
        case (a)
            ACT_CREATE:
            begin
                if (n_created < NTASK)
                begin
                    st.slot = n_created[IDX_W-1:0];
                    st.slot_ok = 1'b1;
                    tsk_prio[n_created] = pr;
                    tsk_state[n_created] = TS_READY;
                    tsk_wake[n_created] = '0;
                    n_created++;
                end
            end
            ACT_LAUNCH:
                pick_highest();
            ACT_TICK:
                advance_tick();
            ACT_BLOCK:
            begin
                if (target_ok)
                    tsk_state[ix] = TS_BLOCKED;
                advance_tick();
            end
            ACT_RESUME:
            begin
                if (target_ok)
                    tsk_state[ix] = TS_READY;
                advance_tick();
            end
            ACT_DELAY:
            begin
                if (dl != '0)
                begin
                    if (target_ok)
                    begin
                        tsk_wake[ix] = dl + tick_cnt;
                        tsk_state[ix] = TS_DELAYED;
                    end
                    advance_tick();
                end
            end
            default:
            begin
            end
        endcase
        st.cur_task = run_vld ? run_idx : '0;
        st.cur_valid = run_vld;
        st.ticks = tick_cnt;
        return st;
    endfunction

    // Directed row whose status can be read straight off the command.
    function void row_typed(input logic [ACTION_W-1:0] a, input logic [IDX_W-1:0] ix,
                            input logic [PRIO_W-1:0] pr, input logic [TICK_W-1:0] dl,
                            input logic [IDX_W-1:0] ct, input logic cv,
                            input logic [IDX_W-1:0] ci, input logic ok,
                            input logic [TICK_W-1:0] tk);
        rows.push_back('{a, ix, pr, dl, 1'b1, '{ct, cv, ci, ok, tk}});
    endfunction

    // Directed row whose status comes from the shadow scheduler.
    function void row_pred(input logic [ACTION_W-1:0] a, input logic [IDX_W-1:0] ix,
                           input logic [PRIO_W-1:0] pr, input logic [TICK_W-1:0] dl);
        rows.push_back('{a, ix, pr, dl, 1'b0, sched_status_t'('0)});
    endfunction

    // Offer one command beat, hold it until taken, then record its status.
    task automatic send_cmd(input logic [ACTION_W-1:0] a, input logic [IDX_W-1:0] ix,
                            input logic [PRIO_W-1:0] pr, input logic [TICK_W-1:0] dl,
                            input logic typed, input sched_status_t typed_res);
        sched_status_t st;
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        task_index <= ix;
        priority_req <= pr;
        delay_ticks <= dl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        st = schedule_cmd(a, ix, pr, dl);
        status_q.push_back(typed ? typed_res : st);
        n_sent++;
    endtask

    // Compare one status beat with the oldest pending status.
    task automatic check_status();
        sched_status_t want;
        if (status_q.size() == 0)
        begin
            $display("%0t: status beat with nothing pending, tick_now %0d", $time, tick_now);
            errors++;
        end
        else
        begin
            want = status_q.pop_front();
            n_checked++;
            if (current_task !== want.cur_task)
            begin
                $display("%0t: current_task expected %0d, got %0d",
                         $time, want.cur_task, current_task);
                errors++;
            end
            if (current_valid !== want.cur_valid)
            begin
                $display("%0t: current_valid expected %0d, got %0d",
                         $time, want.cur_valid, current_valid);
                errors++;
            end
            if (created_index !== want.slot)
            begin
                $display("%0t: created_index expected %0d, got %0d",
                         $time, want.slot, created_index);
                errors++;
            end
            if (create_ok !== want.slot_ok)
            begin
                $display("%0t: create_ok expected %0d, got %0d",
                         $time, want.slot_ok, create_ok);
                errors++;
            end
            if (tick_now !== want.ticks)
            begin
                $display("%0t: tick_now expected %0d, got %0d",
                         $time, want.ticks, tick_now);
                errors++;
            end
        end
    endtask

    // Output side: check beats and stall at random, with one long hold-off.
    initial
    begin : status_sink
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 1'b0;
        out_stall = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_status();
            if (!held && n_checked >= 60)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rcv_idle);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("priority_task_scheduler_tb: done, errors");
        $finish;
    end

    // Main stimulus: reset, directed table, random commands, drain.
    initial
    begin : stimulus
        int          useful;
        int          pick;
        logic [ACTION_W-1:0] a;
        logic [IDX_W-1:0]    ix;
        logic [PRIO_W-1:0]   pr;
        logic [TICK_W-1:0]   dl;

        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_CREATE;
        task_index = '0;
        priority_req = '0;
        delay_ticks = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: ticks advance time but nothing gets selected.
        row_typed(ACT_TICK,    3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd1);
        row_typed(ACT_LAUNCH,  3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd1);
        row_typed(ACT_SPARE_A, 3'd7, 8'hFF, 32'hFFFFFFFF, 3'd0, 1'b0, 3'd0, 1'b0, 32'd1);
        row_typed(ACT_SPARE_B, 3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd1);
        // Target not yet created: the tick still runs.
        row_typed(ACT_BLOCK,   3'd7, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd2);
        // A zero delay runs no tick at all.
        row_typed(ACT_DELAY,   3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd2);
        row_typed(ACT_CREATE,  3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b1, 32'd2);
        // Only a zero-priority task exists, so nothing is eligible.
        row_typed(ACT_TICK,    3'd0, 8'h00, 32'h0,        3'd0, 1'b0, 3'd0, 1'b0, 32'd3);
        row_typed(ACT_CREATE,  3'd0, 8'hFF, 32'h0,        3'd0, 1'b0, 3'd1, 1'b1, 32'd3);
        row_pred (ACT_DELAY,   3'd5, 8'h00, 32'd3);
        // Fill the table; task 1 is running at tick 4 throughout.
        row_typed(ACT_CREATE,  3'd0, 8'h80, 32'h0,        3'd1, 1'b1, 3'd2, 1'b1, 32'd4);
        row_typed(ACT_CREATE,  3'd0, 8'h01, 32'h0,        3'd1, 1'b1, 3'd3, 1'b1, 32'd4);
        row_typed(ACT_CREATE,  3'd0, 8'h7F, 32'h0,        3'd1, 1'b1, 3'd4, 1'b1, 32'd4);
        row_typed(ACT_CREATE,  3'd0, 8'hFE, 32'h0,        3'd1, 1'b1, 3'd5, 1'b1, 32'd4);
        row_typed(ACT_CREATE,  3'd0, 8'h55, 32'h0,        3'd1, 1'b1, 3'd6, 1'b1, 32'd4);
        row_typed(ACT_CREATE,  3'd0, 8'hAA, 32'h0,        3'd1, 1'b1, 3'd7, 1'b1, 32'd4);
        // Table full: the create is refused.
        row_typed(ACT_CREATE,  3'd0, 8'hFF, 32'h0,        3'd1, 1'b1, 3'd0, 1'b0, 32'd4);
        // Repeated launch while a task is already running.
        row_pred (ACT_LAUNCH,  3'd0, 8'h00, 32'h0);
        row_pred (ACT_TICK,    3'd0, 8'h00, 32'h0);
        row_pred (ACT_BLOCK,   3'd5, 8'h00, 32'h0);
        // The wake time wraps around the 32-bit tick count.
        row_pred (ACT_DELAY,   3'd2, 8'h00, 32'hFFFFFFFF);
        row_pred (ACT_DELAY,   3'd3, 8'h00, 32'd1);
        row_pred (ACT_RESUME,  3'd5, 8'h00, 32'h0);
        row_pred (ACT_TICK,    3'd0, 8'h00, 32'h0);
        row_pred (ACT_RESUME,  3'd2, 8'h00, 32'h0);

        foreach (rows[i])
            send_cmd(rows[i].act, rows[i].ix, rows[i].pr, rows[i].dl, rows[i].typed,
                     rows[i].res);

        // Random commands, mostly scheduling traffic with short delays.
        useful = 0;
        while (useful < RANDOM_CMDS)
        begin
            if (useful < RANDOM_CMDS / 3)
            begin
                snd_idle = 16;
                rcv_idle = 59;
            end
            else if (useful < 2 * RANDOM_CMDS / 3)
            begin
                snd_idle = 59;
                rcv_idle = 16;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            pick = $urandom_range(99);
            ix = IDX_W'($urandom_range(NTASK - 1));
            pr = PRIO_W'($urandom_range(255));
            dl = $urandom;
            if (pick < 30)
                a = ACT_TICK;
            else if (pick < 45)
                a = ACT_BLOCK;
            else if (pick < 62)
                a = ACT_RESUME;
            else if (pick < 82)
            begin
                a = ACT_DELAY;
                dl = TICK_W'($urandom_range(24, 1));
            end
            else if (pick < 85)
                a = ACT_DELAY;
            else if (pick < 88)
            begin
                a = ACT_DELAY;
                dl = '0;
            end
            else if (pick < 92)
                a = ACT_LAUNCH;
            else if (pick < 95)
                a = ACT_CREATE;
            else if (pick < 98)
                a = ($urandom_range(1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
            else
                a = ACTION_W'($urandom_range(7));
            send_cmd(a, ix, pr, dl, 1'b0, sched_status_t'('0));
            useful++;
        end
        in_valid <= 1'b0;

        // Drain the outstanding status beats, then give the block time to settle.
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d commands and %0d status beats, reaching tick %0d,",
                 n_sent, n_checked, tick_cnt);
        $display("over three idling mixes and one %0d-cycle output hold-off.", HOLD_CYCLES);
        if (errors == 0)
            $display("priority_task_scheduler_tb: done, clean");
        else
            $display("priority_task_scheduler_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/pts_pkg.sv
sv/priority_task_scheduler.sv
verif/priority_task_scheduler_tb.sv
